// ----- design/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared codes and control types for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    // Command codes carried in the cmd field
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [2:0] CMD_PEEK_REAR  = 3'd5;

    // Status codes returned with every result
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Field widths of the stream words
    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Controller to datapath commands
    typedef struct packed {
        logic load_word;   // take the input word and execute it
    } dq_ctl_t;

endpackage

`default_nettype wire

// ----- design/dq_datapath.sv -----
// ----------------------------------------------------------------------------
// dq_datapath
// Slot memory, front/rear pointers, occupancy and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dq_pkg::dq_ctl_t             ctl,
    input  wire logic [dq_pkg::CMD_W-1:0]    cmd,
    input  wire logic [dq_pkg::WORD_W-1:0]   push_value,
    output logic      [dq_pkg::WORD_W-1:0]   read_value,
    output logic      [dq_pkg::STATUS_W-1:0] status,
    output logic      [dq_pkg::COUNT_W-1:0]  item_count
);
    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // Slot memory
    logic [WORD_W-1:0] slot_mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Queue state
    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] rear_reg,  rear_next;
    logic [CW-1:0] count_reg, count_next;

    // Result registers
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                rd_sel_reg, rd_sel_next;
    logic [CW-1:0]       res_cnt_reg;

    // Memory port controls
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic          q_empty;
    logic          q_full;
    logic [AW-1:0] front_inc, front_dec, rear_inc, rear_dec;
    logic [31:0]   cnt_wide;

    // Wrapped neighbors of both pointers
    always_comb
    begin
        front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;
        front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
        rear_inc  = (rear_reg == LAST_SLOT) ? '0 : rear_reg + 1'b1;
        rear_dec  = (rear_reg == '0) ? LAST_SLOT : rear_reg - 1'b1;
    end

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg >= FULL_CNT);

    // Command decode
    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        rd_sel_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = rear_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        unique case (cmd)
            CMD_PUSH_FRONT:
            begin
                if (q_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_PUSH_REAR:
            begin
                if (q_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = rear_reg;
                    rear_next  = rear_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = front_reg;
                    rd_sel_next = 1'b1;
                    front_next  = front_inc;
                    count_next  = count_reg - 1'b1;
                end
            end
            CMD_POP_REAR:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = rear_dec;
                    rd_sel_next = 1'b1;
                    rear_next   = rear_dec;
                    count_next  = count_reg - 1'b1;
                end
            end
            CMD_PEEK_FRONT:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = front_reg;
                    rd_sel_next = 1'b1;
                end
            end
            CMD_PEEK_REAR:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = rear_dec;
                    rd_sel_next = 1'b1;
                end
            end
            default:
            begin
                // unused codes: no operation
            end
        endcase
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.load_word && wr_en)
        begin
            slot_mem[wr_addr] <= push_value;
        end
        if (ctl.load_word && rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Pointer and occupancy state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctl.load_word)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

    // Result fields, held until the next command is loaded
    always_ff @(posedge clk)
    begin
        if (ctl.load_word)
        begin
            status_reg  <= status_next;
            rd_sel_reg  <= rd_sel_next;
            res_cnt_reg <= count_next;
        end
    end

    assign cnt_wide   = 32'(res_cnt_reg);
    assign read_value = rd_sel_reg ? rd_data_reg : '0;
    assign status     = status_reg;
    assign item_count = cnt_wide[COUNT_W-1:0];

endmodule

`default_nettype wire

// ----- design/dq_controller.sv -----
// ----------------------------------------------------------------------------
// dq_controller
// Handshake control: loads a command and holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_controller (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output dq_pkg::dq_ctl_t      ctl
);
    import dq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_RESULT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   load;

    // Take a word when no result is pending or the pending one leaves now
    assign s_tready      = (state_reg == S_IDLE) || m_tready;
    assign m_tvalid      = (state_reg == S_RESULT);
    assign load          = s_tvalid && s_tready;
    assign ctl.load_word = load;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (m_tready && !load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words in a circular slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one command word per transfer, cmd and push_value.
//   Output stream (m_*): one result word per command: read_value, status
//   and the occupancy after the command.
//   Latency: a result is valid the cycle after its command is taken; the
//   read port of the slot memory is registered, which sets that cycle.
//   Throughput: one command per cycle while the receiver keeps m_tready
//   high; the result register drains and refills at the same edge.
//   Stall: while a result waits with m_tready low, s_tready is low and the
//   result word holds steady.
//   Reset: pointers, occupancy and the handshake clear at once; slot
//   contents are not cleared and no clearing pass is needed, since only
//   occupied slots are ever read.
//   Pop or peek on an empty queue returns status empty, push on a full
//   queue returns status full; neither changes the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] cmd, [34:3] push_value, [39:35] zero
    input  wire logic [dq_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] read_value, [33:32] status, [38:34] item_count, [39] zero
    output logic      [dq_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import dq_pkg::*;

    dq_ctl_t             ctl;
    logic [WORD_W-1:0]   read_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  item_count;

    dq_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cmd        (s_tdata[CMD_W-1:0]),
        .push_value (s_tdata[CMD_W+WORD_W-1:CMD_W]),
        .read_value (read_value),
        .status     (status),
        .item_count (item_count)
    );

    assign m_tdata = {1'b0, item_count, status, read_value};

endmodule

`default_nettype wire

// ----- design/dq_checker.sv -----
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_checker #(
    parameter int DEPTH = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    import dq_pkg::*;

    logic [31:0] cnt_ext;
    assign cnt_ext = 32'(m_tdata[38:34]);

    // A stalled result holds its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Every taken command yields a result on the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted command");

    // With no result pending the input side is open
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Errors carry a zero word and a known status code
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == ST_EMPTY || m_tdata[33:32] == ST_FULL)
        |-> m_tdata[31:0] == 32'd0)
        else $error("error result with nonzero word");

    // Occupancy never exceeds the depth while it fits the count field
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && DEPTH < 32 |-> cnt_ext <= 32'(DEPTH))
        else $error("item count above depth");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for double_ended_queue. A local deque model predicts
// read_value, status and item_count for every accepted command word; a
// monitor on the result stream compares them in order. Directed words cover
// empty, full and unused commands, then biased random traffic fills, drains
// and wraps the circular buffer under three idle and stall profiles.
// ----------------------------------------------------------------------------

module tb;
    import dq_pkg::*;

    localparam int DEPTH = 16;

    // Command codes with no defined operation
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    // Traffic bias for random bursts
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       item_count;
    } dq_result_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [2:0] cmd, [34:3] push_value, [39:35] zero
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [31:0] read_value, [33:32] status, [38:34] item_count, [39] zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Deque model state
    logic [WORD_W-1:0] slot_mem [DEPTH];
    int                head_idx   = 0;
    int                tail_idx   = 0;
    int                fill_level = 0;

    dq_result_t pending_results[$];
    int         mismatch_count = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;

    double_ended_queue #(.DEPTH(DEPTH)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Apply one command to the model and return its result
    function automatic dq_result_t apply_cmd(input logic [2:0] cmd, input logic [31:0] word);
        dq_result_t res;
        res.read_value = '0;
        res.status     = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT:
                if (fill_level >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    slot_mem[head_idx] = word;
                    fill_level++;
                end
            CMD_PUSH_REAR:
                if (fill_level >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    slot_mem[tail_idx] = word;
                    tail_idx = (tail_idx + 1) % DEPTH;
                    fill_level++;
                end
            CMD_POP_FRONT:
                if (fill_level == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.read_value = slot_mem[head_idx];
                    head_idx = (head_idx + 1) % DEPTH;
                    fill_level--;
                end
            CMD_POP_REAR:
                if (fill_level == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                    res.read_value = slot_mem[tail_idx];
                    fill_level--;
                end
            CMD_PEEK_FRONT:
                if (fill_level == 0)
                    res.status = ST_EMPTY;
                else
                    res.read_value = slot_mem[head_idx];
            CMD_PEEK_REAR:
                if (fill_level == 0)
                    res.status = ST_EMPTY;
                else
                    res.read_value = slot_mem[(tail_idx + DEPTH - 1) % DEPTH];
            default: ;
        endcase
        res.item_count = COUNT_W'(fill_level);
        return res;
    endfunction

    // Push value with extra weight on the signed extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Drive one command word, optionally after an idle gap
    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] word);
        int gap;
        if ($urandom_range(99) < src_idle_pct)
        begin
            gap = $urandom_range(4, 1);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, word, cmd};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(apply_cmd(cmd, word));
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        dq_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no command outstanding: %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata[31:0] !== exp_res.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           exp_res.read_value, $signed(m_tdata[31:0]));
                    mismatch_count++;
                end
                if (m_tdata[33:32] !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d",
                           exp_res.status, m_tdata[33:32]);
                    mismatch_count++;
                end
                if (m_tdata[38:34] !== exp_res.item_count)
                begin
                    $error("item_count: expected %0d, got %0d",
                           exp_res.item_count, m_tdata[38:34]);
                    mismatch_count++;
                end
            end
        end
    end

    // Pops and peeks on the empty queue after reset
    task automatic test_empty_queue();
        send_cmd(CMD_POP_FRONT, 32'hFFFF_FFFF);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_PEEK_FRONT, 32'h0);
        send_cmd(CMD_PEEK_REAR, 32'h0);
    endtask

    // Fill from both ends with extremes, bounce off full, then read the ends
    task automatic test_full_queue();
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i % 4)
                0: send_cmd(CMD_PUSH_REAR, 32'h8000_0000);
                1: send_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
                2: send_cmd(CMD_PUSH_REAR, 32'hFFFF_FFFF);
                default: send_cmd(CMD_PUSH_FRONT, $urandom);
            endcase
        end
        send_cmd(CMD_PUSH_FRONT, 32'h1234_5678);
        send_cmd(CMD_PUSH_REAR, 32'h8765_4321);
        send_cmd(CMD_PEEK_FRONT, 32'h0);
        send_cmd(CMD_POP_REAR, 32'h0);
    endtask

    // Commands 6 and 7 leave the queue alone
    task automatic test_unused_cmds();
        send_cmd(CMD_UNUSED_6, 32'hFFFF_FFFF);
        send_cmd(CMD_UNUSED_7, 32'h0);
    endtask

    // Biased bursts so the queue swings between empty and full and wraps
    task automatic test_random_traffic(input int count);
        mix_t        mix;
        int          push_pct;
        int          roll;
        logic [2:0]  cmd;
        mix = MIX_EVEN;
        push_pct = 45;
        for (int i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
            begin
                mix = mix_t'($urandom_range(2));
                case (mix)
                    MIX_FILL:  push_pct = 70;
                    MIX_DRAIN: push_pct = 25;
                    default:   push_pct = 45;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < 3)
                cmd = $urandom_range(1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
            else if ($urandom_range(99) < push_pct)
                cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
            else if ($urandom_range(3) != 0)
                cmd = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
            else
                cmd = $urandom_range(1) ? CMD_PEEK_REAR : CMD_PEEK_FRONT;
            send_cmd(cmd, pick_word());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sparse sender, heavily stalled receiver
        src_idle_pct   = 25;
        sink_stall_pct = 87;
        test_empty_queue();
        test_full_queue();
        test_unused_cmds();
        test_random_traffic(470);

        // Heavily idle sender, mostly ready receiver
        src_idle_pct   = 87;
        sink_stall_pct = 25;
        test_random_traffic(470);

        // Back to back
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_traffic(460);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/dq_pkg.sv
design/dq_datapath.sv
design/dq_controller.sv
design/double_ended_queue.sv
design/dq_checker.sv
dv/tb.sv
